/* hw/rtl/tsw_pkg.sv */
package tsw_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_TEX_WIDTH    = 3'd0;
    localparam logic [2:0] REG_TEX_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_FILTER_MODE  = 3'd2;
    localparam logic [2:0] REG_WRAP_MODE    = 3'd3;
    localparam logic [2:0] REG_BORDER_RED   = 3'd4;
    localparam logic [2:0] REG_BORDER_GREEN = 3'd5;
    localparam logic [2:0] REG_BORDER_BLUE  = 3'd6;

    // Mode codes
    localparam logic       FILTER_NEAREST  = 1'b0;
    localparam logic       FILTER_BILINEAR = 1'b1;
    localparam logic [1:0] WRAP_REPEAT     = 2'd0;
    localparam logic [1:0] WRAP_EDGE       = 2'd1;
    localparam logic [1:0] WRAP_BORDER     = 2'd2;

    // Item kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Coordinate constants, Q7.16
    localparam int Q_ONE  = 65536;
    localparam int Q_HALF = 32768;

    // Register reset values
    localparam logic [6:0] TEX_SIZE_RST = 7'd64;

    typedef struct packed {
        logic [6:0]  tex_width;
        logic [6:0]  tex_height;
        logic        filter_mode;
        logic [1:0]  wrap_mode;
        logic [15:0] border_red;
        logic [15:0] border_green;
        logic [15:0] border_blue;
    } cfg_t;

    // Control that travels with every item down the pipeline
    typedef struct packed {
        logic valid;
        logic kind;
        logic wr_ok;
        logic border;
    } ctl_t;

endpackage

/* hw/rtl/tsw_regs.sv */
module tsw_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tsw_pkg::cfg_t      cfg
);

    tsw_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tex_width    <= tsw_pkg::TEX_SIZE_RST;
            cfg_reg.tex_height   <= tsw_pkg::TEX_SIZE_RST;
            cfg_reg.filter_mode  <= tsw_pkg::FILTER_NEAREST;
            cfg_reg.wrap_mode    <= tsw_pkg::WRAP_REPEAT;
            cfg_reg.border_red   <= '0;
            cfg_reg.border_green <= '0;
            cfg_reg.border_blue  <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                tsw_pkg::REG_TEX_WIDTH:    cfg_reg.tex_width    <= pwdata[6:0];
                tsw_pkg::REG_TEX_HEIGHT:   cfg_reg.tex_height   <= pwdata[6:0];
                tsw_pkg::REG_FILTER_MODE:  cfg_reg.filter_mode  <= pwdata[0];
                tsw_pkg::REG_WRAP_MODE:    cfg_reg.wrap_mode    <= pwdata[1:0];
                tsw_pkg::REG_BORDER_RED:   cfg_reg.border_red   <= pwdata[15:0];
                tsw_pkg::REG_BORDER_GREEN: cfg_reg.border_green <= pwdata[15:0];
                tsw_pkg::REG_BORDER_BLUE:  cfg_reg.border_blue  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (idx)
            tsw_pkg::REG_TEX_WIDTH:    prdata = {25'd0, cfg_reg.tex_width};
            tsw_pkg::REG_TEX_HEIGHT:   prdata = {25'd0, cfg_reg.tex_height};
            tsw_pkg::REG_FILTER_MODE:  prdata = {31'd0, cfg_reg.filter_mode};
            tsw_pkg::REG_WRAP_MODE:    prdata = {30'd0, cfg_reg.wrap_mode};
            tsw_pkg::REG_BORDER_RED:   prdata = {16'd0, cfg_reg.border_red};
            tsw_pkg::REG_BORDER_GREEN: prdata = {16'd0, cfg_reg.border_green};
            tsw_pkg::REG_BORDER_BLUE:  prdata = {16'd0, cfg_reg.border_blue};
            default:                   prdata = '0;
        endcase
    end

endmodule

/* hw/rtl/tsw_addr.sv */
module tsw_addr #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COLOR_BITS = 16,
    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT),
    localparam int CB = COLOR_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  tsw_pkg::cfg_t         cfg,
    input  logic                  in_valid,
    input  logic                  kind,
    input  logic [5:0]            texel_x,
    input  logic [5:0]            texel_y,
    input  logic [15:0]           texel_red,
    input  logic [15:0]           texel_green,
    input  logic [15:0]           texel_blue,
    input  logic signed [23:0]    coord_u,
    input  logic signed [23:0]    coord_v,
    output tsw_pkg::ctl_t         req_ctl,
    output logic [AW-1:0]         req_waddr,
    output logic [3*CB-1:0]       req_wdata,
    output logic [AW-1:0]         req_a00,
    output logic [AW-1:0]         req_a01,
    output logic [AW-1:0]         req_a10,
    output logic [AW-1:0]         req_a11,
    output logic [15:0]           req_fu,
    output logic [15:0]           req_fv
);

    localparam int WB  = $clog2(MAX_WIDTH + 1);
    localparam int HB  = $clog2(MAX_HEIGHT + 1);
    localparam int PU  = 24 + WB + 1;
    localparam int PV  = 24 + HB + 1;
    localparam int UB  = PU - 16;
    localparam int VB  = PV - 16;
    localparam int NST = (UB > VB) ? UB : VB;
    localparam int XB  = $clog2(MAX_WIDTH);
    localparam int YB  = $clog2(MAX_HEIGHT);

    typedef struct packed {
        tsw_pkg::ctl_t   ctl;
        logic            nu;
        logic            nv;
        logic [UB-1:0]   ru;
        logic [VB-1:0]   rv;
        logic [15:0]     fu;
        logic [15:0]     fv;
        logic [AW-1:0]   waddr;
        logic [3*CB-1:0] wdata;
    } stage_t;

    // Effective texture size
    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    logic          clamp;

    always_comb
    begin
        if (cfg.tex_width == 7'd0)
            w_eff = WB'(1);
        else if (32'(cfg.tex_width) > MAX_WIDTH)
            w_eff = WB'(MAX_WIDTH);
        else
            w_eff = WB'(cfg.tex_width);
        if (cfg.tex_height == 7'd0)
            h_eff = HB'(1);
        else if (32'(cfg.tex_height) > MAX_HEIGHT)
            h_eff = HB'(MAX_HEIGHT);
        else
            h_eff = HB'(cfg.tex_height);
    end

    assign clamp = (cfg.wrap_mode == tsw_pkg::WRAP_EDGE) ||
                   (cfg.wrap_mode == tsw_pkg::WRAP_BORDER);

    // Stage A: clamp, border test, scale to texel space
    logic signed [23:0]   u_c, v_c;
    logic signed [PU-1:0] u_ext, w_ext, tu_next;
    logic signed [PV-1:0] v_ext, h_ext, tv_next;
    logic                 u_out, v_out;
    tsw_pkg::ctl_t        ctl_a_next, ctl_a_reg;
    logic signed [PU-1:0] tu_reg;
    logic signed [PV-1:0] tv_reg;
    logic [AW-1:0]        waddr_a_next, waddr_a_reg;
    logic [3*CB-1:0]      wdata_a_next, wdata_a_reg;

    always_comb
    begin
        u_out = (coord_u < 0) || (32'(coord_u) > tsw_pkg::Q_ONE);
        v_out = (coord_v < 0) || (32'(coord_v) > tsw_pkg::Q_ONE);
        u_c = coord_u;
        v_c = coord_v;
        if (clamp)
        begin
            if (coord_u < 0)
                u_c = '0;
            else if (u_out)
                u_c = 24'(tsw_pkg::Q_ONE);
            if (coord_v < 0)
                v_c = '0;
            else if (v_out)
                v_c = 24'(tsw_pkg::Q_ONE);
        end
        u_ext   = PU'(u_c);
        v_ext   = PV'(v_c);
        w_ext   = $signed(PU'(w_eff));
        h_ext   = $signed(PV'(h_eff));
        tu_next = u_ext * w_ext - PU'(tsw_pkg::Q_HALF);
        tv_next = v_ext * h_ext - PV'(tsw_pkg::Q_HALF);

        ctl_a_next.valid  = in_valid;
        ctl_a_next.kind   = kind;
        ctl_a_next.wr_ok  = (32'(texel_x) < MAX_WIDTH) && (32'(texel_y) < MAX_HEIGHT);
        ctl_a_next.border = (cfg.wrap_mode == tsw_pkg::WRAP_BORDER) && (u_out || v_out);
        waddr_a_next = AW'(32'(texel_y) * MAX_WIDTH + 32'(texel_x));
        wdata_a_next = {texel_blue[CB-1:0], texel_green[CB-1:0], texel_red[CB-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_a_reg <= '0;
        else if (en)
            ctl_a_reg <= ctl_a_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tu_reg      <= tu_next;
            tv_reg      <= tv_next;
            waddr_a_reg <= waddr_a_next;
            wdata_a_reg <= wdata_a_next;
        end
    end

    // Stage B: sign, magnitude of the truncated index, fractions
    stage_t               pipe_reg  [0:NST];
    stage_t               pipe_next [0:NST];
    logic signed [PU-1:0] mag_u;
    logic signed [PV-1:0] mag_v;
    logic [UB+WB-1:0]     sub_u [0:NST-1];
    logic [VB+HB-1:0]     sub_v [0:NST-1];

    // Then modulo by size: one restoring compare-subtract per stage, high bit first
    always_comb
    begin
        mag_u = tu_reg[PU-1] ? -tu_reg : tu_reg;
        mag_v = tv_reg[PV-1] ? -tv_reg : tv_reg;
        pipe_next[0].ctl   = ctl_a_reg;
        pipe_next[0].nu    = tu_reg[PU-1];
        pipe_next[0].nv    = tv_reg[PV-1];
        pipe_next[0].ru    = mag_u[PU-1:16];
        pipe_next[0].rv    = mag_v[PV-1:16];
        pipe_next[0].fu    = (cfg.filter_mode == tsw_pkg::FILTER_BILINEAR) ?
                             tu_reg[15:0] : 16'd0;
        pipe_next[0].fv    = (cfg.filter_mode == tsw_pkg::FILTER_BILINEAR) ?
                             tv_reg[15:0] : 16'd0;
        pipe_next[0].waddr = waddr_a_reg;
        pipe_next[0].wdata = wdata_a_reg;
        for (int s = 0; s < NST; s++)
        begin
            pipe_next[s+1] = pipe_reg[s];
            sub_u[s] = (UB+WB)'(w_eff) << (NST - 1 - s);
            sub_v[s] = (VB+HB)'(h_eff) << (NST - 1 - s);
            if ((NST - 1 - s) < UB && (UB+WB)'(pipe_reg[s].ru) >= sub_u[s])
                pipe_next[s+1].ru = pipe_reg[s].ru - sub_u[s][UB-1:0];
            if ((NST - 1 - s) < VB && (VB+HB)'(pipe_reg[s].rv) >= sub_v[s])
                pipe_next[s+1].rv = pipe_reg[s].rv - sub_v[s][VB-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NST; s++)
                pipe_reg[s] <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s <= NST; s++)
                pipe_reg[s] <= pipe_next[s];
        end
    end

    // Final index, neighbor index and the four tap addresses
    stage_t        fin;
    logic [WB-1:0] mu, xu, xp;
    logic [HB-1:0] mv, yv, yp;
    logic [XB-1:0] x0, x1;
    logic [YB-1:0] y0, y1;

    always_comb
    begin
        fin = pipe_reg[NST];
        mu  = WB'(fin.ru);
        mv  = HB'(fin.rv);
        // negative remainder folds back into range
        xu  = (fin.nu && mu != '0) ? w_eff - mu : mu;
        yv  = (fin.nv && mv != '0) ? h_eff - mv : mv;
        xp  = xu + WB'(1);
        yp  = yv + HB'(1);
        if (clamp)
        begin
            xp = (xp >= w_eff) ? w_eff - WB'(1) : xp;
            yp = (yp >= h_eff) ? h_eff - HB'(1) : yp;
        end
        else
        begin
            xp = (xp == w_eff) ? '0 : xp;
            yp = (yp == h_eff) ? '0 : yp;
        end
        x0 = XB'(xu);
        x1 = XB'(xp);
        y0 = YB'(yv);
        y1 = YB'(yp);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_ctl <= '0;
        else if (en)
            req_ctl <= fin.ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            req_a00   <= AW'(32'(y0) * MAX_WIDTH + 32'(x0));
            req_a01   <= AW'(32'(y0) * MAX_WIDTH + 32'(x1));
            req_a10   <= AW'(32'(y1) * MAX_WIDTH + 32'(x0));
            req_a11   <= AW'(32'(y1) * MAX_WIDTH + 32'(x1));
            req_fu    <= fin.fu;
            req_fv    <= fin.fv;
            req_waddr <= fin.waddr;
            req_wdata <= fin.wdata;
        end
    end

endmodule

/* hw/rtl/tsw_mem.sv */
module tsw_mem #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COLOR_BITS = 16,
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
    localparam int AW    = $clog2(DEPTH),
    localparam int DW    = 3 * COLOR_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tsw_pkg::ctl_t   req_ctl,
    input  logic [AW-1:0]   req_waddr,
    input  logic [DW-1:0]   req_wdata,
    input  logic [AW-1:0]   req_a00,
    input  logic [AW-1:0]   req_a01,
    input  logic [AW-1:0]   req_a10,
    input  logic [AW-1:0]   req_a11,
    input  logic [15:0]     req_fu,
    input  logic [15:0]     req_fv,
    output tsw_pkg::ctl_t   rsp_ctl,
    output logic [DW-1:0]   rsp_t00,
    output logic [DW-1:0]   rsp_t01,
    output logic [DW-1:0]   rsp_t10,
    output logic [DW-1:0]   rsp_t11,
    output logic [15:0]     rsp_fu,
    output logic [15:0]     rsp_fv
);

    // Four copies of the texture, one per bilinear tap. Writes land in all
    // of them at the same stage the taps are read, so program order holds.
    logic          wen;
    logic [AW-1:0] raddr [0:3];
    logic [DW-1:0] rdata [0:3];

    assign wen = en && req_ctl.valid && (req_ctl.kind == tsw_pkg::KIND_WRITE) &&
                 req_ctl.wr_ok;
    assign raddr[0] = req_a00;
    assign raddr[1] = req_a01;
    assign raddr[2] = req_a10;
    assign raddr[3] = req_a11;

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [DW-1:0] mem [0:DEPTH-1];

        always_ff @(posedge clk)
        begin
            if (wen)
                mem[req_waddr] <= req_wdata;
            if (en)
                rdata[b] <= mem[raddr[b]];
        end
    end

    assign rsp_t00 = rdata[0];
    assign rsp_t01 = rdata[1];
    assign rsp_t10 = rdata[2];
    assign rsp_t11 = rdata[3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ctl <= '0;
        else if (en)
            rsp_ctl <= req_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rsp_fu <= req_fu;
            rsp_fv <= req_fv;
        end
    end

endmodule

/* hw/rtl/tsw_filter.sv */
module tsw_filter #(
    parameter int COLOR_BITS = 16,
    localparam int CB = COLOR_BITS,
    localparam int DW = 3 * COLOR_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  tsw_pkg::cfg_t   cfg,
    input  tsw_pkg::ctl_t   rsp_ctl,
    input  logic [DW-1:0]   rsp_t00,
    input  logic [DW-1:0]   rsp_t01,
    input  logic [DW-1:0]   rsp_t10,
    input  logic [DW-1:0]   rsp_t11,
    input  logic [15:0]     rsp_fu,
    input  logic [15:0]     rsp_fv,
    output logic            out_valid,
    output logic [15:0]     out_red,
    output logic [15:0]     out_green,
    output logic [15:0]     out_blue
);

    // a + (b - a) * f / 65536 with the product term truncated toward zero
    function automatic logic [CB-1:0] mix1(input logic [CB-1:0] a,
                                           input logic [CB-1:0] b,
                                           input logic [15:0]   f);
        logic [CB-1:0]    d;
        logic [CB+15:0]   p;
        d = (b >= a) ? b - a : a - b;
        p = (CB+16)'(d) * (CB+16)'(f);
        return (b >= a) ? a + p[CB+15:16] : a - p[CB+15:16];
    endfunction

    // Horizontal pass
    tsw_pkg::ctl_t ctl_h_reg;
    logic [DW-1:0] h0_next, h1_next, h0_reg, h1_reg;
    logic [15:0]   fv_h_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            h0_next[k*CB +: CB] = mix1(rsp_t00[k*CB +: CB], rsp_t01[k*CB +: CB], rsp_fu);
            h1_next[k*CB +: CB] = mix1(rsp_t10[k*CB +: CB], rsp_t11[k*CB +: CB], rsp_fu);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_h_reg <= '0;
        else if (en)
            ctl_h_reg <= rsp_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h0_reg   <= h0_next;
            h1_reg   <= h1_next;
            fv_h_reg <= rsp_fv;
        end
    end

    // Vertical pass and border select into the output register
    logic [DW-1:0] v_next, col_reg;
    logic          out_valid_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
            v_next[k*CB +: CB] = mix1(h0_reg[k*CB +: CB], h1_reg[k*CB +: CB], fv_h_reg);
        if (ctl_h_reg.border)
            v_next = {cfg.border_blue[CB-1:0], cfg.border_green[CB-1:0],
                      cfg.border_red[CB-1:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ctl_h_reg.valid && (ctl_h_reg.kind == tsw_pkg::KIND_SAMPLE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
            col_reg <= v_next;
    end

    assign out_valid = out_valid_reg;
    assign out_red   = 16'(col_reg[0*CB +: CB]);
    assign out_green = 16'(col_reg[1*CB +: CB]);
    assign out_blue  = 16'(col_reg[2*CB +: CB]);

endmodule

/* hw/rtl/texture_sampler_wrap_filter_top.sv */
// Path: a sample goes through stage A, stage B, N modulo stages (N is the index width of
//   u * width, 16 at the default sizes), tap addresses, tap read, horizontal pass, output.
// One item per cycle unless the output stalls; the four taps read four replicated copies.
// Writes produce no result and update the texture at the tap-read stage, in order.
// Reset (async, active low) clears valids and config registers; texture is not cleared.
module texture_sampler_wrap_filter_top #(
    parameter int MAX_WIDTH  = 64,
    parameter int MAX_HEIGHT = 64,
    parameter int COLOR_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               kind,
    input  logic [5:0]         texel_x,
    input  logic [5:0]         texel_y,
    input  logic [15:0]        texel_red,
    input  logic [15:0]        texel_green,
    input  logic [15:0]        texel_blue,
    input  logic signed [23:0] coord_u,
    input  logic signed [23:0] coord_v,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        out_red,
    output logic [15:0]        out_green,
    output logic [15:0]        out_blue
);

    localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int DW = 3 * COLOR_BITS;

    tsw_pkg::cfg_t cfg;
    tsw_pkg::ctl_t req_ctl, rsp_ctl;
    logic          en;
    logic [AW-1:0] req_waddr, req_a00, req_a01, req_a10, req_a11;
    logic [DW-1:0] req_wdata, rsp_t00, rsp_t01, rsp_t10, rsp_t11;
    logic [15:0]   req_fu, req_fv, rsp_fu, rsp_fv;

    // Whole pipeline moves unless the output holds an untaken result
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    tsw_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsw_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .kind        (kind),
        .texel_x     (texel_x),
        .texel_y     (texel_y),
        .texel_red   (texel_red),
        .texel_green (texel_green),
        .texel_blue  (texel_blue),
        .coord_u     (coord_u),
        .coord_v     (coord_v),
        .req_ctl     (req_ctl),
        .req_waddr   (req_waddr),
        .req_wdata   (req_wdata),
        .req_a00     (req_a00),
        .req_a01     (req_a01),
        .req_a10     (req_a10),
        .req_a11     (req_a11),
        .req_fu      (req_fu),
        .req_fv      (req_fv)
    );

    tsw_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS)
    ) u_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .req_ctl   (req_ctl),
        .req_waddr (req_waddr),
        .req_wdata (req_wdata),
        .req_a00   (req_a00),
        .req_a01   (req_a01),
        .req_a10   (req_a10),
        .req_a11   (req_a11),
        .req_fu    (req_fu),
        .req_fv    (req_fv),
        .rsp_ctl   (rsp_ctl),
        .rsp_t00   (rsp_t00),
        .rsp_t01   (rsp_t01),
        .rsp_t10   (rsp_t10),
        .rsp_t11   (rsp_t11),
        .rsp_fu    (rsp_fu),
        .rsp_fv    (rsp_fv)
    );

    tsw_filter #(
        .COLOR_BITS (COLOR_BITS)
    ) u_filter (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .cfg       (cfg),
        .rsp_ctl   (rsp_ctl),
        .rsp_t00   (rsp_t00),
        .rsp_t01   (rsp_t01),
        .rsp_t10   (rsp_t10),
        .rsp_t11   (rsp_t11),
        .rsp_fu    (rsp_fu),
        .rsp_fv    (rsp_fv),
        .out_valid (out_valid),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

`ifndef ASSERT_OFF
    // Input is refused only while a result waits at the output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled without output backpressure");

    // A stalled output freezes the tap-read stage
    a_mem_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(rsp_ctl))
        else $error("memory stage moved during stall");

    // A new result appears only after a pipeline advance
    a_out_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(en))
        else $error("result appeared without pipeline advance");
`endif

endmodule
